@@ rtl/core/wheel_slip_detector_defines.svh @@
// Assertion macros for the wheel slip detector.
// Used by the modules that check their own logic; needs clk and rst in scope.
`ifndef WHEEL_SLIP_DETECTOR_DEFINES_SVH
`define WHEEL_SLIP_DETECTOR_DEFINES_SVH
`ifndef SYNTHESIS
`define WSD_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("wheel slip detector: same-cycle check failed");
`define WSD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("wheel slip detector: next-cycle check failed");
`else
`define WSD_ASSERT_SAME(label, ante, cons)
`define WSD_ASSERT_NEXT(label, ante, cons)
`endif
`endif

@@ rtl/core/wsd_pkg.sv @@
// Shared types, constants and helpers of the wheel slip detector.
// No dependencies.
package wsd_pkg;

  localparam int FIELD_WIDTH = 32;
  localparam int COUNT_WIDTH = 32;
  localparam int RATIO_WIDTH = 8;
  localparam int MIN_WIDTH   = 16;
  localparam int RUN_WIDTH   = 8;
  localparam int PROD_WIDTH  = COUNT_WIDTH + RATIO_WIDTH;

  localparam int APB_ADDR_WIDTH = 4;
  localparam int APB_DATA_WIDTH = 32;

  typedef logic [COUNT_WIDTH-1:0] cnt_t;
  typedef logic [PROD_WIDTH-1:0]  prod_t;
  typedef logic [RUN_WIDTH-1:0]   run_t;
  typedef logic [1:0]             side_t;
  typedef logic [1:0]             reg_idx_t;

  localparam side_t SIDE_NONE  = 2'd0;
  localparam side_t SIDE_LEFT  = 2'd1;
  localparam side_t SIDE_RIGHT = 2'd2;

  localparam reg_idx_t REG_SLIP_RATIO = 2'd0;
  localparam reg_idx_t REG_MIN_MOTOR  = 2'd1;
  localparam reg_idx_t REG_TRIGGER    = 2'd2;

  localparam logic [RATIO_WIDTH-1:0] SLIP_RATIO_RESET = 8'd4;
  localparam logic [MIN_WIDTH-1:0]   MIN_MOTOR_RESET  = 16'd100;
  localparam run_t                   TRIGGER_RESET    = 8'd3;

  localparam run_t RUN_MAX = {RUN_WIDTH{1'b1}};
  localparam run_t RUN_ONE = run_t'(1);

  typedef struct packed {
    logic [RATIO_WIDTH-1:0] slip_ratio;
    logic [MIN_WIDTH-1:0]   min_motor_delta;
    run_t                   trigger_count;
  } wsd_cfg_t;

  // Per-tick delta magnitudes and motor directions.
  typedef struct packed {
    cnt_t lw_mag;
    cnt_t rw_mag;
    cnt_t lm_mag;
    cnt_t rm_mag;
    logic lm_pos;
    logic rm_pos;
  } wsd_mag_t;

  // Magnitude of a two's complement delta; the most negative value maps to 2^(W-1).
  function automatic cnt_t delta_mag(input cnt_t d);
    delta_mag = d[COUNT_WIDTH-1] ? cnt_t'(~d + cnt_t'(1)) : d;
  endfunction

  function automatic logic delta_pos(input cnt_t d);
    delta_pos = !d[COUNT_WIDTH-1] && (d != '0);
  endfunction

endpackage

@@ rtl/core/wsd_cfg.sv @@
// Configuration register file behind an APB-style port.
// Depends on wsd_pkg.
module wsd_cfg
  import wsd_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [APB_ADDR_WIDTH-1:0] paddr,
  input  logic [APB_DATA_WIDTH-1:0] pwdata,
  output logic [APB_DATA_WIDTH-1:0] prdata,
  output logic                      pready,
  output wsd_cfg_t                  cfg
);

  reg_idx_t idx;
  logic     wr;

  assign pready = 1'b1;
  assign idx    = paddr[APB_ADDR_WIDTH-1:2];
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.slip_ratio      <= SLIP_RATIO_RESET;
      cfg.min_motor_delta <= MIN_MOTOR_RESET;
      cfg.trigger_count   <= TRIGGER_RESET;
    end else if (wr) begin
      unique case (idx)
        REG_SLIP_RATIO: cfg.slip_ratio      <= pwdata[RATIO_WIDTH-1:0];
        REG_MIN_MOTOR:  cfg.min_motor_delta <= pwdata[MIN_WIDTH-1:0];
        REG_TRIGGER:    cfg.trigger_count   <= pwdata[RUN_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_SLIP_RATIO: prdata = APB_DATA_WIDTH'(cfg.slip_ratio);
      REG_MIN_MOTOR:  prdata = APB_DATA_WIDTH'(cfg.min_motor_delta);
      REG_TRIGGER:    prdata = APB_DATA_WIDTH'(cfg.trigger_count);
      default:        prdata = '0;
    endcase
  end

endmodule

@@ rtl/core/wsd_delta.sv @@
// Input stage: keeps the previous positions and registers the magnitudes and motor directions of the wrapping deltas.
// Depends on wsd_pkg.
module wsd_delta
  import wsd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [FIELD_WIDTH-1:0] left_wheel_count,
  input  logic [FIELD_WIDTH-1:0] right_wheel_count,
  input  logic [FIELD_WIDTH-1:0] left_motor_count,
  input  logic [FIELD_WIDTH-1:0] right_motor_count,
  input  logic                   advance,
  output logic                   mag_valid,
  output wsd_mag_t               mag
);

  cnt_t prev_lw, prev_rw, prev_lm, prev_rm;
  cnt_t cur_lw, cur_rw, cur_lm, cur_rm;
  cnt_t d_lw, d_rw, d_lm, d_rm;
  logic load;

  assign cur_lw = left_wheel_count[COUNT_WIDTH-1:0];
  assign cur_rw = right_wheel_count[COUNT_WIDTH-1:0];
  assign cur_lm = left_motor_count[COUNT_WIDTH-1:0];
  assign cur_rm = right_motor_count[COUNT_WIDTH-1:0];

  assign d_lw = cur_lw - prev_lw;
  assign d_rw = cur_rw - prev_rw;
  assign d_lm = cur_lm - prev_lm;
  assign d_rm = cur_rm - prev_rm;

  assign in_stall = mag_valid && !advance;
  assign load     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_lw   <= '0;
      prev_rw   <= '0;
      prev_lm   <= '0;
      prev_rm   <= '0;
      mag_valid <= 1'b0;
    end else begin
      if (load) begin
        prev_lw <= cur_lw;
        prev_rw <= cur_rw;
        prev_lm <= cur_lm;
        prev_rm <= cur_rm;
      end
      if (load) begin
        mag_valid <= 1'b1;
      end else if (advance) begin
        mag_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      mag.lw_mag <= delta_mag(d_lw);
      mag.rw_mag <= delta_mag(d_rw);
      mag.lm_mag <= delta_mag(d_lm);
      mag.rm_mag <= delta_mag(d_rm);
      mag.lm_pos <= delta_pos(d_lm);
      mag.rm_pos <= delta_pos(d_rm);
    end
  end

endmodule

@@ rtl/core/wsd_judge.sv @@
// Result stage: slip test per side, run counter and the result register.
// Depends on wsd_pkg and wheel_slip_detector_defines.svh.
`include "wheel_slip_detector_defines.svh"
module wsd_judge
  import wsd_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  wsd_cfg_t cfg,
  input  logic     mag_valid,
  input  wsd_mag_t mag,
  output logic     advance,
  output logic     out_valid,
  input  logic     out_stall,
  output logic     slip_event,
  output side_t    slip_side,
  output logic     moving_forward,
  output run_t     slip_run_length
);

  prod_t lw_lim, rw_lim;
  cnt_t  min_ext;
  logic  slip_l, slip_r;
  side_t side_next;
  logic  fwd_next;
  run_t  run_count, run_next;
  logic  load;

  assign lw_lim  = prod_t'(cfg.slip_ratio) * prod_t'(mag.lw_mag);
  assign rw_lim  = prod_t'(cfg.slip_ratio) * prod_t'(mag.rw_mag);
  assign min_ext = cnt_t'(cfg.min_motor_delta);

  assign slip_l = (prod_t'(mag.lm_mag) > lw_lim) && (mag.lm_mag > min_ext);
  assign slip_r = (prod_t'(mag.rm_mag) > rw_lim) && (mag.rm_mag > min_ext);

  // Left wins when both sides slip.
  always_comb begin
    priority if (slip_l) begin
      side_next = SIDE_LEFT;
      fwd_next  = mag.lm_pos;
    end else if (slip_r) begin
      side_next = SIDE_RIGHT;
      fwd_next  = mag.rm_pos;
    end else begin
      side_next = SIDE_NONE;
      fwd_next  = 1'b0;
    end
  end

  always_comb begin
    if (side_next == SIDE_NONE) begin
      run_next = '0;
    end else if (run_count == RUN_MAX) begin
      run_next = run_count;
    end else begin
      run_next = run_count + RUN_ONE;
    end
  end

  assign advance         = !out_valid || !out_stall;
  assign load            = mag_valid && advance;
  assign slip_run_length = run_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      run_count <= '0;
    end else begin
      if (advance) begin
        out_valid <= mag_valid;
      end
      if (load) begin
        run_count <= run_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slip_event     <= run_next > cfg.trigger_count;
      slip_side      <= side_next;
      moving_forward <= fwd_next;
    end
  end

  `WSD_ASSERT_SAME(a_event_has_side, out_valid && slip_event, slip_side != SIDE_NONE)
  `WSD_ASSERT_NEXT(a_run_step, load && side_next != SIDE_NONE && run_count != RUN_MAX, run_count == $past(run_count) + RUN_ONE)
  `WSD_ASSERT_NEXT(a_run_clear, load && side_next == SIDE_NONE, run_count == '0 && !moving_forward)

endmodule

@@ rtl/core/wheel_slip_detector.sv @@
// Wheel slip detector top level: config registers, delta stage, result stage.
// A word accepted by the delta stage is registered there, then moves to the result register
// when the result stage advances, and is taken from there while out_stall is low.
// Throughput: one word per cycle while out_stall is low; the loop is the run counter in the result stage.
// Reset (synchronous, rst high): previous positions and run count clear to zero,
// registers return to ratio 4, minimum delta 100, trigger count 3, no word held.
module wheel_slip_detector
  import wsd_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [APB_ADDR_WIDTH-1:0]     paddr,
  input  logic [APB_DATA_WIDTH-1:0]     pwdata,
  output logic [APB_DATA_WIDTH-1:0]     prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [FIELD_WIDTH-1:0] left_wheel_count,
  input  logic signed [FIELD_WIDTH-1:0] right_wheel_count,
  input  logic signed [FIELD_WIDTH-1:0] left_motor_count,
  input  logic signed [FIELD_WIDTH-1:0] right_motor_count,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          slip_event,
  output side_t                         slip_side,
  output logic                          moving_forward,
  output run_t                          slip_run_length
);

  wsd_cfg_t cfg;
  wsd_mag_t mag;
  logic     mag_valid;
  logic     advance;

  wsd_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  wsd_delta u_delta (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .left_wheel_count  (left_wheel_count),
    .right_wheel_count (right_wheel_count),
    .left_motor_count  (left_motor_count),
    .right_motor_count (right_motor_count),
    .advance           (advance),
    .mag_valid         (mag_valid),
    .mag               (mag)
  );

  wsd_judge u_judge (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .mag_valid       (mag_valid),
    .mag             (mag),
    .advance         (advance),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .slip_event      (slip_event),
    .slip_side       (slip_side),
    .moving_forward  (moving_forward),
    .slip_run_length (slip_run_length)
  );

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for wheel_slip_detector: directed ticks, then random phases.
// Predicts results from its own slip model or takes them from the directed table; needs wsd_pkg and the RTL only.
`timescale 1ns / 1ps

module tb;
  import wsd_pkg::*;

  typedef struct packed {
    logic  ev;
    side_t side;
    logic  fwd;
    run_t  run;
  } slip_res_t;

  typedef struct packed {
    cnt_t      lw;
    cnt_t      rw;
    cnt_t      lm;
    cnt_t      rm;
    logic      typed;
    slip_res_t res;
  } stim_row_t;

  localparam int DIR_N = 17;
  localparam int PHASE_ITEMS = 210;

  // Reset settings apply: ratio 4, minimum 100, trigger 3.
  localparam stim_row_t DIR_ROWS [DIR_N] = '{
    '{32'd0, 32'd0, 32'd0, 32'd0, 1'b1, '{1'b0, SIDE_NONE, 1'b0, 8'd0}},
    '{32'd0, 32'd0, 32'd101, 32'd0, 1'b1, '{1'b0, SIDE_LEFT, 1'b1, 8'd1}},
    '{32'd0, 32'd0, 32'd101, 32'hFFFF_FF38, 1'b1, '{1'b0, SIDE_RIGHT, 1'b0, 8'd2}},
    '{32'd0, 32'd0, 32'd0, 32'hFFFF_FF38, 1'b1, '{1'b0, SIDE_LEFT, 1'b0, 8'd3}},
    '{32'd0, 32'd0, 32'd101, 32'hFFFF_FF38, 1'b1, '{1'b1, SIDE_LEFT, 1'b1, 8'd4}},
    '{32'd0, 32'd0, 32'd300, 32'd0, 1'b1, '{1'b1, SIDE_LEFT, 1'b1, 8'd5}},
    '{32'd0, 32'd0, 32'd400, 32'd0, 1'b1, '{1'b0, SIDE_NONE, 1'b0, 8'd0}},
    '{32'd50, 32'd0, 32'd600, 32'd0, 1'b1, '{1'b0, SIDE_NONE, 1'b0, 8'd0}},
    '{32'd100, 32'd0, 32'd801, 32'd0, 1'b1, '{1'b0, SIDE_LEFT, 1'b1, 8'd1}},
    '{32'd100, 32'd0, 32'h8000_0321, 32'd0, 1'b1, '{1'b0, SIDE_LEFT, 1'b0, 8'd2}},
    '{32'd100, 32'd25, 32'h8000_0321, 32'd101, 1'b1, '{1'b0, SIDE_RIGHT, 1'b1, 8'd3}},
    '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, '0},
    '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, '0},
    '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0},
    '{32'd0, 32'd0, 32'd0, 32'd0, 1'b0, '0},
    '{32'd0, 32'd0, 32'h7FFF_FFFF, 32'd0, 1'b0, '0},
    '{32'd0, 32'd0, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, '0}
  };

  localparam logic [7:0]  PH_RATIO [5] = '{8'd4, 8'd0, 8'd255, 8'd1, 8'd128};
  localparam logic [15:0] PH_MIN   [5] = '{16'd100, 16'd0, 16'd65535, 16'd1, 16'd32768};
  localparam logic [7:0]  PH_TRIG  [5] = '{8'd3, 8'd0, 8'd255, 8'd1, 8'd128};

  logic clk, rst;
  logic psel, penable, pwrite;
  logic [APB_ADDR_WIDTH-1:0] paddr;
  logic [APB_DATA_WIDTH-1:0] pwdata, prdata;
  logic pready;
  logic in_valid, in_stall, out_valid, out_stall;
  logic signed [FIELD_WIDTH-1:0] left_wheel_count, right_wheel_count;
  logic signed [FIELD_WIDTH-1:0] left_motor_count, right_motor_count;
  logic slip_event, moving_forward;
  side_t slip_side;
  run_t slip_run_length;

  wheel_slip_detector u_dut (.*);

  // predictor state
  logic [RATIO_WIDTH-1:0] cfg_ratio;
  logic [MIN_WIDTH-1:0]   cfg_min;
  run_t                   cfg_trig;
  cnt_t prev_lw, prev_rw, prev_lm, prev_rm;
  run_t run_count;

  slip_res_t expected_ticks [$];
  int  mismatches;
  int  items_sent;
  int  send_idle, recv_idle;
  bit  hold_req;

  // random tick shaping
  bit  seg_slip, seg_long;
  int  seg_left;
  logic [1:0] seg_side;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5000000;
    $display("** wheel_slip_detector: FAILED **");
    $finish;
  end

  task automatic note_mismatch(input string what);
    $display("mismatch at %0t: %s", $time, what);
    mismatches++;
  endtask

  task automatic check_field(input string name, input int got, input int exp_v);
    if (got != exp_v) note_mismatch($sformatf("%s got %0d, wanted %0d", name, got, exp_v));
  endtask

  function automatic cnt_t mag_of(cnt_t d);
    return d[COUNT_WIDTH-1] ? cnt_t'(0) - d : d;
  endfunction

  function automatic bit slips(cnt_t d_motor, cnt_t d_wheel);
    longint unsigned mm, bound;
    mm = mag_of(d_motor);
    bound = longint'(cfg_ratio) * longint'(mag_of(d_wheel));
    return mm > bound && mm > longint'(cfg_min);
  endfunction

  function automatic slip_res_t predict_tick(cnt_t lw, cnt_t rw, cnt_t lm, cnt_t rm);
    slip_res_t r;
    cnt_t dlm, drm;
    r = '0;
    dlm = lm - prev_lm;
    drm = rm - prev_rm;
    // left wins when both sides slip
    if (slips(dlm, lw - prev_lw)) begin
      r.side = SIDE_LEFT;
      r.fwd = !dlm[COUNT_WIDTH-1] && dlm != '0;
    end else if (slips(drm, rw - prev_rw)) begin
      r.side = SIDE_RIGHT;
      r.fwd = !drm[COUNT_WIDTH-1] && drm != '0;
    end
    if (r.side != SIDE_NONE) begin
      if (run_count != RUN_MAX) run_count++;
    end else begin
      run_count = '0;
    end
    prev_lw = lw;
    prev_rw = rw;
    prev_lm = lm;
    prev_rm = rm;
    r.run = run_count;
    r.ev = run_count > cfg_trig;
    return r;
  endfunction

  // Called at a falling edge; returns at the falling edge after the word is taken.
  task automatic send_word(input cnt_t lw, input cnt_t rw, input cnt_t lm, input cnt_t rm,
                           input logic typed, input slip_res_t res);
    slip_res_t pred;
    if (items_sent < 420) begin
      send_idle = 34;
      recv_idle = 52;
    end else if (items_sent < 840) begin
      send_idle = 52;
      recv_idle = 34;
    end else begin
      send_idle = 0;
      recv_idle = 0;
    end
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    left_wheel_count <= lw;
    right_wheel_count <= rw;
    left_motor_count <= lm;
    right_motor_count <= rm;
    do @(posedge clk); while (in_stall);
    pred = predict_tick(lw, rw, lm, rm);
    expected_ticks.push_back(typed ? res : pred);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (expected_ticks.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [APB_DATA_WIDTH-1:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== val) note_mismatch($sformatf("reg %0d read %0h, wrote %0h", idx, prdata, val));
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_SLIP_RATIO: cfg_ratio = val[RATIO_WIDTH-1:0];
      REG_MIN_MOTOR:  cfg_min = val[MIN_WIDTH-1:0];
      REG_TRIGGER:    cfg_trig = val[RUN_WIDTH-1:0];
      default: ;
    endcase
  endtask

  // Mostly runs of slip and clean ticks built on the last positions; some noise.
  task automatic gen_tick(output cnt_t lw, output cnt_t rw, output cnt_t lm, output cnt_t rm);
    int pick, wl, wr;
    longint unsigned ml, mr;
    cnt_t ext [5];
    ext = '{32'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'd1};
    pick = $urandom_range(0, 99);
    if (pick < 12 && !seg_long) begin
      lw = $urandom;
      rw = $urandom;
      lm = $urandom;
      rm = $urandom;
    end else if (pick < 20 && !seg_long) begin
      lw = prev_lw + ext[$urandom_range(0, 4)];
      rw = prev_rw + ext[$urandom_range(0, 4)];
      lm = prev_lm + ext[$urandom_range(0, 4)];
      rm = prev_rm + ext[$urandom_range(0, 4)];
    end else begin
      if (seg_left == 0) begin
        seg_slip = !seg_slip;
        seg_long = 1'b0;
        if (seg_slip) begin
          seg_side = $urandom_range(1, 3);
          seg_long = $urandom_range(0, 99) < 8;
          seg_left = seg_long ? $urandom_range(256, 300) : $urandom_range(1, 8);
        end else begin
          seg_left = $urandom_range(1, 4);
        end
      end
      seg_left--;
      if (seg_left == 0) seg_long = 1'b0;
      wl = int'($urandom_range(0, 100)) - 50;
      wr = int'($urandom_range(0, 100)) - 50;
      if (seg_slip && seg_side[0])
        ml = cfg_min + cfg_ratio * (wl < 0 ? -wl : wl) + 1 + $urandom_range(0, 300);
      else
        ml = $urandom_range(0, cfg_min);
      if (seg_slip && seg_side[1])
        mr = cfg_min + cfg_ratio * (wr < 0 ? -wr : wr) + 1 + $urandom_range(0, 300);
      else
        mr = $urandom_range(0, cfg_min);
      lw = prev_lw + cnt_t'(wl);
      rw = prev_rw + cnt_t'(wr);
      lm = $urandom_range(0, 1) ? prev_lm - cnt_t'(ml) : prev_lm + cnt_t'(ml);
      rm = $urandom_range(0, 1) ? prev_rm - cnt_t'(mr) : prev_rm + cnt_t'(mr);
    end
  endtask

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (79) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        out_stall <= $urandom_range(0, 99) < recv_idle;
      end
    end
  end

  always @(posedge clk) begin : check_out
    slip_res_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_ticks.size() == 0) begin
        note_mismatch("result word with none expected");
      end else begin
        want = expected_ticks.pop_front();
        check_field("slip_event", slip_event, want.ev);
        check_field("slip_side", slip_side, want.side);
        check_field("moving_forward", moving_forward, want.fwd);
        check_field("slip_run_length", slip_run_length, want.run);
      end
    end
  end

  initial begin
    cnt_t lw, rw, lm, rm;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid = 1'b0;
    left_wheel_count = '0;
    right_wheel_count = '0;
    left_motor_count = '0;
    right_motor_count = '0;
    cfg_ratio = SLIP_RATIO_RESET;
    cfg_min = MIN_MOTOR_RESET;
    cfg_trig = TRIGGER_RESET;
    prev_lw = '0;
    prev_rw = '0;
    prev_lm = '0;
    prev_rm = '0;
    run_count = '0;
    mismatches = 0;
    items_sent = 0;
    send_idle = 34;
    recv_idle = 52;
    hold_req = 1'b0;
    seg_slip = 1'b0;
    seg_long = 1'b0;
    seg_left = 0;
    seg_side = 2'd1;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int i = 0; i < DIR_N; i++)
      send_word(DIR_ROWS[i].lw, DIR_ROWS[i].rw, DIR_ROWS[i].lm, DIR_ROWS[i].rm,
                DIR_ROWS[i].typed, DIR_ROWS[i].res);

    for (int ph = 0; ph < 6; ph++) begin
      drain();
      if (ph < 5) begin
        write_reg(REG_SLIP_RATIO, PH_RATIO[ph]);
        write_reg(REG_MIN_MOTOR, PH_MIN[ph]);
        write_reg(REG_TRIGGER, PH_TRIG[ph]);
      end else begin
        write_reg(REG_SLIP_RATIO, $urandom_range(0, 255));
        write_reg(REG_MIN_MOTOR, $urandom_range(0, 65535));
        write_reg(REG_TRIGGER, $urandom_range(0, 255));
      end
      // long slip run so the counter saturates under the widest settings
      if (ph == 2) begin
        seg_slip = 1'b1;
        seg_long = 1'b1;
        seg_side = 2'd1;
        seg_left = 280;
      end
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (ph * PHASE_ITEMS + k == 300 || ph * PHASE_ITEMS + k == 1000) hold_req = 1'b1;
        gen_tick(lw, rw, lm, rm);
        send_word(lw, rw, lm, rm, 1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    while (expected_ticks.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("** wheel_slip_detector: PASSED **");
    end else begin
      $display("** wheel_slip_detector: FAILED **");
    end
    $finish;
  end

endmodule
